// File: hdl/ata_pio_pkg.sv
// types, register offsets and command codes shared by the ata pio command issue block
package ata_pio_pkg;

    localparam int MAX_RESULTS = 10;
    localparam int NUM_W       = 4;

    // task-file register offsets
    localparam logic [2:0] REG_DATA    = 3'd0;
    localparam logic [2:0] REG_COUNT   = 3'd2;
    localparam logic [2:0] REG_LBA_LO  = 3'd3;
    localparam logic [2:0] REG_LBA_MID = 3'd4;
    localparam logic [2:0] REG_LBA_HI  = 3'd5;
    localparam logic [2:0] REG_DRIVE   = 3'd6;
    localparam logic [2:0] REG_CMD     = 3'd7;

    // drive and command bytes
    localparam logic [7:0] DRV_EXT       = 8'h40;
    localparam logic [7:0] DRV_LBA28     = 8'hE0;
    localparam logic [7:0] DRV_SLAVE     = 8'h10;
    localparam logic [7:0] CMD_READ      = 8'h20;
    localparam logic [7:0] CMD_READ_EXT  = 8'h24;
    localparam logic [7:0] CMD_WRITE     = 8'h30;
    localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

    localparam logic [48:0] LIMIT_28        = 49'h1 << 28;
    localparam logic [16:0] SMALL_COUNT_MAX = 17'd256;

    localparam logic [NUM_W-1:0] N_REFUSED = 4'd1;
    localparam logic [NUM_W-1:0] N_LBA28   = 4'd6;
    localparam logic [NUM_W-1:0] N_EXT     = 4'd10;

    typedef enum logic [1:0] {
        FORM_REFUSED,
        FORM_LBA28,
        FORM_EXT
    } t_form;

    typedef struct packed {
        logic [47:0] start_lba;
        logic [16:0] sector_count;
        logic        write_access;
        logic        slave_select;
        logic        lba48_supported;
    } t_req;

    typedef struct packed {
        logic [2:0] reg_offset;
        logic [7:0] reg_value;
        logic       refused;
        logic       last_write;
    } t_result;

    typedef struct packed {
        logic [NUM_W-1:0]              n_items;
        t_result [MAX_RESULTS-1:0]     items;
    } t_seq;

    function automatic t_result mk_write(logic [2:0] off, logic [7:0] val, logic last);
        t_result r;
        r.reg_offset = off;
        r.reg_value  = val;
        r.refused    = 1'b0;
        r.last_write = last;
        return r;
    endfunction

endpackage

// File: hdl/ata_pio_decode.sv
// decodes one registered request into its list of task-file writes
module ata_pio_decode (
    input  ata_pio_pkg::t_req i_req,
    output ata_pio_pkg::t_seq o_seq
);
    import ata_pio_pkg::*;

    logic [48:0] w_end;
    logic        w_bad_count;
    logic        w_past_28;
    logic        w_past_48;
    logic        w_big_count;
    logic        w_ext;
    t_form       w_form;
    logic [7:0]  w_slave;
    logic [47:0] lba;
    logic [16:0] cnt;

    assign lba         = i_req.start_lba;
    assign cnt         = i_req.sector_count;
    assign w_end       = {1'b0, lba} + {32'd0, cnt};
    assign w_bad_count = (cnt == 17'd0) || (cnt[16] && (cnt[15:0] != 16'd0));
    assign w_past_28   = w_end > LIMIT_28;
    assign w_past_48   = w_end[48] && (w_end[47:0] != 48'd0);
    assign w_big_count = cnt > SMALL_COUNT_MAX;
    assign w_ext       = i_req.lba48_supported && (w_past_28 || w_big_count);
    assign w_slave     = i_req.slave_select ? DRV_SLAVE : 8'h00;

    always_comb begin
        if (w_bad_count) begin
            w_form = FORM_REFUSED;
        end else if (w_ext) begin
            w_form = w_past_48 ? FORM_REFUSED : FORM_EXT;
        end else if (w_past_28 || w_big_count) begin
            w_form = FORM_REFUSED;
        end else begin
            w_form = FORM_LBA28;
        end
    end

    always_comb begin
        o_seq = '0;
        case (w_form)
            FORM_EXT: begin
                o_seq.n_items  = N_EXT;
                o_seq.items[0] = mk_write(REG_DRIVE, DRV_EXT | w_slave, 1'b0);
                o_seq.items[1] = mk_write(REG_COUNT, cnt[15:8], 1'b0);
                o_seq.items[2] = mk_write(REG_LBA_LO, lba[31:24], 1'b0);
                o_seq.items[3] = mk_write(REG_LBA_MID, lba[39:32], 1'b0);
                o_seq.items[4] = mk_write(REG_LBA_HI, lba[47:40], 1'b0);
                o_seq.items[5] = mk_write(REG_COUNT, cnt[7:0], 1'b0);
                o_seq.items[6] = mk_write(REG_LBA_LO, lba[7:0], 1'b0);
                o_seq.items[7] = mk_write(REG_LBA_MID, lba[15:8], 1'b0);
                o_seq.items[8] = mk_write(REG_LBA_HI, lba[23:16], 1'b0);
                o_seq.items[9] = mk_write(REG_CMD,
                    i_req.write_access ? CMD_WRITE_EXT : CMD_READ_EXT, 1'b1);
            end
            FORM_LBA28: begin
                o_seq.n_items  = N_LBA28;
                o_seq.items[0] = mk_write(REG_DRIVE,
                    DRV_LBA28 | w_slave | {4'h0, lba[27:24]}, 1'b0);
                o_seq.items[1] = mk_write(REG_COUNT, cnt[7:0], 1'b0);
                o_seq.items[2] = mk_write(REG_LBA_LO, lba[7:0], 1'b0);
                o_seq.items[3] = mk_write(REG_LBA_MID, lba[15:8], 1'b0);
                o_seq.items[4] = mk_write(REG_LBA_HI, lba[23:16], 1'b0);
                o_seq.items[5] = mk_write(REG_CMD,
                    i_req.write_access ? CMD_WRITE : CMD_READ, 1'b1);
            end
            default: begin
                o_seq.n_items             = N_REFUSED;
                o_seq.items[0].reg_offset = REG_DATA;
                o_seq.items[0].reg_value  = 8'h00;
                o_seq.items[0].refused    = 1'b1;
                o_seq.items[0].last_write = 1'b1;
            end
        endcase
    end

endmodule

// File: hdl/ata_pio_command_issue.sv
// ata pio command issue: one transfer request in, task-file register writes out
//
//   channel   handshake                 payload
//   request   start in, busy out        i_req    (t_req)
//   result    o_strobe out, no stall    o_result (t_result)
//
// a request accepted at one edge is held in the request register until the shifter
// takes it, decoded, and its writes leave a shift register one per cycle
// a request issues 10 writes (extended form), 6 (28-bit form) or 1 (refused),
// issued by the output shift register, one write per cycle
// the next request is taken while the previous one is still being issued, so a
// request waiting in the request register follows with no gap between writes
// reset clears the request valid flag and the outstanding write count
// busy is high only while a decoded request waits for the shifter to drain
module ata_pio_command_issue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ata_pio_pkg::t_req    i_req,
    output logic                 o_strobe,
    output ata_pio_pkg::t_result o_result
);
    import ata_pio_pkg::*;

    logic                      r_req_valid, n_req_valid;
    t_req                      r_req;
    logic [NUM_W-1:0]          r_left, n_left;
    t_result [MAX_RESULTS-1:0] r_seq, n_seq;
    t_seq                      w_seq;
    logic                      w_move;
    logic                      w_accept;

    ata_pio_decode u_decode (
        .i_req (r_req),
        .o_seq (w_seq)
    );

    // hand over to the shifter once it is empty or on its final write
    assign w_move   = r_req_valid && (r_left <= 4'd1);
    assign busy     = r_req_valid && !w_move;
    assign w_accept = start && !busy;

    assign o_strobe = r_left != '0;
    assign o_result = r_seq[0];

    always_comb begin
        n_req_valid = r_req_valid;
        if (w_accept) begin
            n_req_valid = 1'b1;
        end else if (w_move) begin
            n_req_valid = 1'b0;
        end
    end

    always_comb begin
        n_left = r_left;
        n_seq  = r_seq;
        if (w_move) begin
            n_left = w_seq.n_items;
            n_seq  = w_seq.items;
        end else if (r_left != '0) begin
            n_left = r_left - 4'd1;
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                n_seq[i] = r_seq[i+1];
            end
            n_seq[MAX_RESULTS-1] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_left      <= '0;
        end else begin
            r_req_valid <= n_req_valid;
            r_left      <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        r_seq <= n_seq;
    end

    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_req_valid)
        else $error("accepted request not held");

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left > 4'd1) |=> o_strobe)
        else $error("gap inside a write sequence");

    a_busy_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_req_valid && o_strobe))
        else $error("busy without a pending request");

    a_refused_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.refused) |-> (o_result.last_write && r_left == 4'd1))
        else $error("refused result not alone");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_left == 4'd1) |-> o_result.last_write)
        else $error("final write not marked");

endmodule
